FILE: rtl/core/salc_pkg.sv
`timescale 1ns / 1ps
// Package for the set-associative LRU tag store: geometry constants,
// register indexes and the controller state type. No dependencies.
package salc_pkg;

   localparam int WAYS        = 8;
   localparam int SETS        = 2;
   localparam int BLOCK_BYTES = 32;

   localparam int ADDR_W   = 32;
   localparam int COST_W   = 16;
   localparam int SUM_W    = 32;
   localparam int WAY_OUT_W = 3;
   localparam int CSR_IDX_W = 8;

   localparam int OFFSET_W = $clog2(BLOCK_BYTES);
   localparam int SET_BITS = $clog2(SETS);
   localparam int SET_W    = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_W    = ADDR_W - OFFSET_W - SET_BITS;
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;

   localparam logic [CSR_IDX_W-1:0] CSR_HIT_COST  = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MISS_COST = CSR_IDX_W'(1);

   localparam logic [COST_W-1:0] HIT_COST_RESET  = COST_W'(4);
   localparam logic [COST_W-1:0] MISS_COST_RESET = COST_W'(836);

   typedef logic [TAG_W-1:0] tag_type;
   typedef logic [WAY_W-1:0] rank_type;

   typedef enum logic {
      ST_IDLE,
      ST_LOOKUP
   } state_type;

endpackage

FILE: rtl/core/set_assoc_lru_cache_stall.sv
`timescale 1ns / 1ps
// Top level of the set-associative LRU tag store with stall accumulator.
// An accepted item's set, tag and memory rows are registered, then its result.
// A new item is taken only once the last finishes, due to the read-modify-write
// of the tag and rank memories. A stalled result holds the lookup until taken.
// Reset clears valid bits, rank init flags and the stall sum, and restores costs.
module set_assoc_lru_cache_stall
   import salc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [ADDR_W-1:0]    req_address,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_hit,
   output logic [WAY_OUT_W-1:0] rsp_way,
   output logic [SUM_W-1:0]     rsp_stall_total,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COST_W-1:0]    csr_wdata
);

   state_type state_ff, state_in;

   logic [COST_W-1:0] hit_cost_ff, miss_cost_ff;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   logic [SET_W-1:0]  set_ff;
   tag_type           tag_ff;

   logic [WAYS*TAG_W-1:0] tag_mem [SETS];
   logic [WAYS*WAY_W-1:0] rank_mem [SETS];
   logic [WAYS*TAG_W-1:0] tag_rd_ff;
   logic [WAYS*WAY_W-1:0] rank_rd_ff;
   logic                  rank_init_rd_ff;
   logic [SETS-1:0]       rank_init_ff;
   logic [WAYS-1:0]       valid_ff [SETS];

   logic                  rsp_valid_ff;
   logic                  rsp_hit_ff;
   logic [WAY_OUT_W-1:0]  rsp_way_ff;
   logic [SUM_W-1:0]      rsp_sum_ff;

   logic                  req_take;
   logic                  finish;
   logic [SET_W-1:0]      req_set;
   tag_type               req_tag;

   logic [WAYS-1:0]       row_valid;
   rank_type              rank_cur [WAYS];
   logic [WAYS*WAY_W-1:0] rank_new;
   logic                  hit;
   logic [WAY_W-1:0]      hit_way, free_way, lru_way, chosen;
   logic                  free_found;
   rank_type              old_rank;
   logic [SUM_W:0]        sum_wide;

   assign req_set = SET_W'(req_address >> OFFSET_W) & SET_W'(SETS - 1);
   assign req_tag = TAG_W'(req_address >> (OFFSET_W + SET_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_stall = 1'b1;
      req_take  = 1'b0;
      finish    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_take = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (!(rsp_valid_ff && rsp_stall)) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_cost_ff  <= HIT_COST_RESET;
         miss_cost_ff <= MISS_COST_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_HIT_COST) begin
            hit_cost_ff <= csr_wdata;
         end else if (csr_index == CSR_MISS_COST) begin
            miss_cost_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         set_ff          <= req_set;
         tag_ff          <= req_tag;
         tag_rd_ff       <= tag_mem[req_set];
         rank_rd_ff      <= rank_mem[req_set];
         rank_init_rd_ff <= rank_init_ff[req_set];
      end
   end

   always_comb begin
      row_valid = valid_ff[set_ff];
      for (int w = 0; w < WAYS; w++) begin
         rank_cur[w] = rank_init_rd_ff ? rank_rd_ff[w*WAY_W +: WAY_W] : WAY_W'(w);
      end
      hit        = 1'b0;
      hit_way    = '0;
      free_found = 1'b0;
      free_way   = '0;
      lru_way    = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (row_valid[w] && tag_rd_ff[w*TAG_W +: TAG_W] == tag_ff) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
         if (!row_valid[w]) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
         if (rank_cur[w] == WAY_W'(WAYS - 1)) begin
            lru_way = WAY_W'(w);
         end
      end
      if (hit) begin
         chosen = hit_way;
      end else if (free_found) begin
         chosen = free_way;
      end else begin
         chosen = lru_way;
      end
      old_rank = rank_cur[chosen];
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_W'(w) == chosen) begin
            rank_new[w*WAY_W +: WAY_W] = '0;
         end else if (rank_cur[w] < old_rank) begin
            rank_new[w*WAY_W +: WAY_W] = rank_cur[w] + WAY_W'(1);
         end else begin
            rank_new[w*WAY_W +: WAY_W] = rank_cur[w];
         end
      end
      sum_wide = {1'b0, sum_ff} + (SUM_W + 1)'(hit ? hit_cost_ff : miss_cost_ff);
      sum_in   = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rank_mem[set_ff] <= rank_new;
         if (!hit) begin
            tag_mem[set_ff][chosen*TAG_W +: TAG_W] <= tag_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_init_ff <= '0;
         sum_ff       <= '0;
         for (int s = 0; s < SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else if (finish) begin
         rank_init_ff[set_ff]     <= 1'b1;
         valid_ff[set_ff][chosen] <= 1'b1;
         sum_ff                   <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_hit_ff <= hit;
         rsp_way_ff <= WAY_OUT_W'(chosen);
         rsp_sum_ff <= sum_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_way         = rsp_way_ff;
   assign rsp_stall_total = rsp_sum_ff;

endmodule
